// File: sv/dtfq_pkg.sv
// ----------------------------------------------------------------------------
// dtfq_pkg
// shared types and constants of the due-time / fuel priority queue
// ----------------------------------------------------------------------------
package dtfq_pkg;

  localparam int KIND_W    = 2;
  localparam int FUEL_W    = 17;
  localparam int SLOT_W    = 8;
  localparam int OUT_CNT_W = 5;
  localparam int ERR_W     = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_COUNT  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_t;

  typedef struct packed {
    kind_t kind;
    logic  urgent;
  } req_ctrl_t;

endpackage

// File: sv/due_time_fuel_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// due_time_fuel_priority_queue_unit
// ordered queue of entries sorted by due time and fuel, stream interface
// ----------------------------------------------------------------------------
// requests arrive on s_axis: tuser carries the kind (insert, remove head,
// count due entries), tdata the entry fields and the current time. every
// request gives exactly one result on m_axis with the due count, the head
// entry after the operation, the occupancy, an empty flag and an error code.
// a request first lands in a two-entry queue; the back end takes it, runs
// the per-cell compares into the decide stage registers and the prefix
// select and shift in the next cycle, then loads the cells and the result
// register. the back end takes no new request until the previous one has
// committed its shift, so the next request sees the updated order.
// reset empties the entry array at once (only the entry count is cleared,
// not the cells) and drops any queued request. when m_axis_tready is low the
// result is held, the back end stalls after its compare cycle, and s_axis
// keeps taking requests until the two-entry queue is full.
// ----------------------------------------------------------------------------
module due_time_fuel_priority_queue_unit #(
  parameter int CAPACITY  = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // desired_time, fuel_left, urgent, slot_number, now_time, zero pad
  input  logic [((2 * TIME_BITS + 26 + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // kind
  input  logic [dtfq_pkg::KIND_W-1:0]                  s_axis_tuser,
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // due_count, head_time, head_fuel, head_urgent, head_slot, occupancy,
  // is_empty, error_flag, zero pad
  output logic [((TIME_BITS + 39 + 7) / 8) * 8 - 1:0]  m_axis_tdata
);
  import dtfq_pkg::*;

  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OUT_W    = ((TIME_BITS + 39 + 7) / 8) * 8;
  localparam int FUEL_LO  = TIME_BITS;
  localparam int URG_BIT  = FUEL_LO + FUEL_W;
  localparam int SLOT_LO  = URG_BIT + 1;
  localparam int NOW_LO   = SLOT_LO + SLOT_W;

  logic                     req_valid;
  logic                     req_ready;
  req_ctrl_t                req_ctrl;
  logic [TIME_BITS-1:0]     req_time;
  logic signed [FUEL_W-1:0] req_fuel;
  logic [SLOT_W-1:0]        req_slot;

  logic [CNT_W-1:0]         res_due;
  logic [TIME_BITS-1:0]     res_head_time;
  logic signed [FUEL_W-1:0] res_head_fuel;
  logic                     res_head_urgent;
  logic [SLOT_W-1:0]        res_head_slot;
  logic [CNT_W-1:0]         res_occupancy;
  logic                     res_empty;
  err_t                     res_err;
  logic [31:0]              due_wide;
  logic [31:0]              occ_wide;

  dtfq_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_axis_tvalid),
    .in_ready        (s_axis_tready),
    .in_kind         (s_axis_tuser),
    .in_desired_time (s_axis_tdata[TIME_BITS-1:0]),
    .in_fuel         (s_axis_tdata[URG_BIT-1:FUEL_LO]),
    .in_urgent       (s_axis_tdata[URG_BIT]),
    .in_slot         (s_axis_tdata[NOW_LO-1:SLOT_LO]),
    .in_now_time     (s_axis_tdata[NOW_LO+TIME_BITS-1:NOW_LO]),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req_ctrl        (req_ctrl),
    .req_time        (req_time),
    .req_fuel        (req_fuel),
    .req_slot        (req_slot)
  );

  dtfq_back #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (TIME_BITS),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req_ctrl        (req_ctrl),
    .req_time        (req_time),
    .req_fuel        (req_fuel),
    .req_slot        (req_slot),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_due         (res_due),
    .out_head_time   (res_head_time),
    .out_head_fuel   (res_head_fuel),
    .out_head_urgent (res_head_urgent),
    .out_head_slot   (res_head_slot),
    .out_occupancy   (res_occupancy),
    .out_empty       (res_empty),
    .out_err         (res_err)
  );

  // counts are reported modulo the 5-bit field
  assign due_wide = 32'(res_due);
  assign occ_wide = 32'(res_occupancy);

  assign m_axis_tdata = OUT_W'({res_err, res_empty, occ_wide[OUT_CNT_W-1:0], res_head_slot,
                                res_head_urgent, res_head_fuel, res_head_time,
                                due_wide[OUT_CNT_W-1:0]});

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> res_occupancy <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res_err == ERR_FULL |-> res_occupancy == CNT_W'(CAPACITY) && !res_empty)
    else $error("full error reported while queue not full");

  a_empty_drop: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res_err == ERR_EMPTY |-> res_empty && res_occupancy == '0)
    else $error("empty error reported while queue holds entries");

  a_due_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> res_due <= res_occupancy)
    else $error("due count above occupancy");

endmodule

// File: sv/dtfq_front.sv
// ----------------------------------------------------------------------------
// dtfq_front
// accepts requests, decodes the kind, picks the compare time and holds
// them in a two-entry queue ahead of the entry array
// ----------------------------------------------------------------------------
module dtfq_front #(
  parameter int TIME_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [dtfq_pkg::KIND_W-1:0]          in_kind,
  input  logic [TIME_BITS-1:0]                 in_desired_time,
  input  logic signed [dtfq_pkg::FUEL_W-1:0]   in_fuel,
  input  logic                                 in_urgent,
  input  logic [dtfq_pkg::SLOT_W-1:0]          in_slot,
  input  logic [TIME_BITS-1:0]                 in_now_time,
  output logic                                 req_valid,
  input  logic                                 req_ready,
  output dtfq_pkg::req_ctrl_t                  req_ctrl,
  output logic [TIME_BITS-1:0]                 req_time,
  output logic signed [dtfq_pkg::FUEL_W-1:0]   req_fuel,
  output logic [dtfq_pkg::SLOT_W-1:0]          req_slot
);
  import dtfq_pkg::*;

  localparam int DEPTH  = 2;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  req_ctrl_t                q_ctrl [DEPTH];
  logic [TIME_BITS-1:0]     q_time [DEPTH];
  logic signed [FUEL_W-1:0] q_fuel [DEPTH];
  logic [SLOT_W-1:0]        q_slot [DEPTH];

  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              push;
  logic              pop;
  req_ctrl_t         dec_ctrl;
  logic [TIME_BITS-1:0] dec_time;

  // count requests compare against now, inserts against their own time
  always_comb begin
    dec_ctrl.kind   = kind_t'(in_kind);
    dec_ctrl.urgent = in_urgent;
    dec_time        = (dec_ctrl.kind == KIND_COUNT) ? in_now_time : in_desired_time;
  end

  assign in_ready  = (fill != FILL_W'(DEPTH));
  assign req_valid = (fill != '0);
  assign push      = in_valid & in_ready;
  assign pop       = req_valid & req_ready;

  always_comb begin
    fill_next = fill;
    if (push && !pop) begin
      fill_next = fill + FILL_W'(1);
    end else if (pop && !push) begin
      fill_next = fill - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_ctrl[wr_ptr] <= dec_ctrl;
      q_time[wr_ptr] <= dec_time;
      q_fuel[wr_ptr] <= in_fuel;
      q_slot[wr_ptr] <= in_slot;
    end
  end

  assign req_ctrl = q_ctrl[rd_ptr];
  assign req_time = q_time[rd_ptr];
  assign req_fuel = q_fuel[rd_ptr];
  assign req_slot = q_slot[rd_ptr];

endmodule

// File: sv/dtfq_back.sv
// ----------------------------------------------------------------------------
// dtfq_back
// ordered entry cells: per-cell compares into the decide stage registers,
// then prefix select and shift, then the result register
// ----------------------------------------------------------------------------
module dtfq_back #(
  parameter int CAPACITY  = 16,
  parameter int TIME_BITS = 16,
  parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  dtfq_pkg::req_ctrl_t                  req_ctrl,
  input  logic [TIME_BITS-1:0]                 req_time,
  input  logic signed [dtfq_pkg::FUEL_W-1:0]   req_fuel,
  input  logic [dtfq_pkg::SLOT_W-1:0]          req_slot,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [CNT_W-1:0]                     out_due,
  output logic [TIME_BITS-1:0]                 out_head_time,
  output logic signed [dtfq_pkg::FUEL_W-1:0]   out_head_fuel,
  output logic                                 out_head_urgent,
  output logic [dtfq_pkg::SLOT_W-1:0]          out_head_slot,
  output logic [CNT_W-1:0]                     out_occupancy,
  output logic                                 out_empty,
  output dtfq_pkg::err_t                       out_err
);
  import dtfq_pkg::*;

  function automatic logic [CAPACITY-1:0] low_mask(input int idx);
    logic [CAPACITY-1:0] m;
    m = ~({CAPACITY{1'b1}} << (idx + 1));
    return m;
  endfunction

  // entry cells
  logic [TIME_BITS-1:0]     cell_time   [CAPACITY];
  logic signed [FUEL_W-1:0] cell_fuel   [CAPACITY];
  logic                     cell_urgent [CAPACITY];
  logic [SLOT_W-1:0]        cell_slot   [CAPACITY];
  logic [TIME_BITS-1:0]     time_next   [CAPACITY];
  logic signed [FUEL_W-1:0] fuel_next   [CAPACITY];
  logic                     urgent_next [CAPACITY];
  logic [SLOT_W-1:0]        slot_next   [CAPACITY];
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;

  state_t state;
  state_t state_next;
  logic   take;
  logic   commit;

  // decide stage registers
  logic [CAPACITY-1:0]      dec_a;
  logic [CAPACITY-1:0]      dec_b;
  req_ctrl_t                dec_ctrl;
  logic [TIME_BITS-1:0]     dec_time;
  logic signed [FUEL_W-1:0] dec_fuel;
  logic [SLOT_W-1:0]        dec_slot;
  err_t                     dec_err;

  logic [CAPACITY-1:0] cmp_a;
  logic [CAPACITY-1:0] cmp_b;
  err_t                cmp_err;

  logic [CAPACITY-1:0] p1;
  logic [CAPACITY-1:0] sel;
  logic [CAPACITY-1:0] q;
  logic [CAPACITY-1:0] qprev;
  logic [CNT_W-1:0]    pos;
  logic                do_insert;
  logic                do_remove;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (req_valid) state_next = ST_APPLY;
      ST_APPLY: if (commit) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = (state == ST_IDLE);
    take      = req_ready & req_valid;
    commit    = (state == ST_APPLY) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // per-cell compares against the request at the queue head
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cmp_a[i] = (CNT_W'(i) < count) && (cell_time[i] <= req_time);
      cmp_b[i] = (CNT_W'(i) < count) && (cell_fuel[i] < req_fuel);
    end
    cmp_err = ERR_OK;
    if (req_ctrl.kind == KIND_INSERT && count == CNT_W'(CAPACITY)) begin
      cmp_err = ERR_FULL;
    end else if (req_ctrl.kind == KIND_REMOVE && count == '0) begin
      cmp_err = ERR_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dec_a    <= cmp_a;
      dec_b    <= cmp_b;
      dec_ctrl <= req_ctrl;
      dec_time <= req_time;
      dec_fuel <= req_fuel;
      dec_slot <= req_slot;
      dec_err  <= cmp_err;
    end
  end

  // leading runs: time skip first (non-urgent only), then fuel skip
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      p1[i] = !dec_ctrl.urgent && (&(dec_a | ~low_mask(i)));
    end
    sel = (dec_ctrl.kind == KIND_COUNT) ? dec_a : (p1 | dec_b);
    for (int i = 0; i < CAPACITY; i++) begin
      q[i] = &(sel | ~low_mask(i));
    end
    qprev = {q[CAPACITY-2:0], 1'b1};
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (qprev[i] && !q[i]) begin
        pos = pos | CNT_W'(i);
      end
    end
    if (q[CAPACITY-1]) begin
      pos = pos | CNT_W'(CAPACITY);
    end
  end

  assign do_insert = (dec_ctrl.kind == KIND_INSERT) && (dec_err == ERR_OK);
  assign do_remove = (dec_ctrl.kind == KIND_REMOVE) && (dec_err == ERR_OK);

  always_comb begin
    count_next = count;
    if (do_insert) begin
      count_next = count + CNT_W'(1);
    end else if (do_remove) begin
      count_next = count - CNT_W'(1);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    always_comb begin
      time_next[g]   = cell_time[g];
      fuel_next[g]   = cell_fuel[g];
      urgent_next[g] = cell_urgent[g];
      slot_next[g]   = cell_slot[g];
      if (do_insert && !q[g]) begin
        if (qprev[g]) begin
          time_next[g]   = dec_time;
          fuel_next[g]   = dec_fuel;
          urgent_next[g] = dec_ctrl.urgent;
          slot_next[g]   = dec_slot;
        end else begin
          time_next[g]   = cell_time[(g == 0) ? 0 : g - 1];
          fuel_next[g]   = cell_fuel[(g == 0) ? 0 : g - 1];
          urgent_next[g] = cell_urgent[(g == 0) ? 0 : g - 1];
          slot_next[g]   = cell_slot[(g == 0) ? 0 : g - 1];
        end
      end else if (do_remove && g < CAPACITY - 1) begin
        time_next[g]   = cell_time[(g < CAPACITY - 1) ? g + 1 : g];
        fuel_next[g]   = cell_fuel[(g < CAPACITY - 1) ? g + 1 : g];
        urgent_next[g] = cell_urgent[(g < CAPACITY - 1) ? g + 1 : g];
        slot_next[g]   = cell_slot[(g < CAPACITY - 1) ? g + 1 : g];
      end
    end

    always_ff @(posedge clk) begin
      if (commit) begin
        cell_time[g]   <= time_next[g];
        cell_fuel[g]   <= fuel_next[g];
        cell_urgent[g] <= urgent_next[g];
        cell_slot[g]   <= slot_next[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (commit) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, head taken from the updated cells
  always_ff @(posedge clk) begin
    if (commit) begin
      out_due       <= (dec_ctrl.kind == KIND_COUNT) ? pos : '0;
      out_occupancy <= count_next;
      out_empty     <= (count_next == '0);
      out_err       <= dec_err;
      if (count_next != '0) begin
        out_head_time   <= time_next[0];
        out_head_fuel   <= fuel_next[0];
        out_head_urgent <= urgent_next[0];
        out_head_slot   <= slot_next[0];
      end else begin
        out_head_time   <= '0;
        out_head_fuel   <= '0;
        out_head_urgent <= 1'b0;
        out_head_slot   <= '0;
      end
    end
  end

endmodule
